// ----- design/idxs_pkg.sv -----
`timescale 1ns / 1ps

package idxs_pkg;

    localparam int WORD_W    = 32;
    localparam int CNT_W     = 9;
    localparam int REM_W     = CNT_W + 1;
    localparam int PICK_W    = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    typedef logic [1:0] t_status;

    localparam t_status ST_DRAWN   = 2'd0;
    localparam t_status ST_RESTART = 2'd1;
    localparam t_status ST_EMPTY   = 2'd2;
    localparam t_status ST_LIMIT   = 2'd3;

    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_DRAW    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WITH_REPL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_LIMIT = 2'd2;

endpackage

// ----- design/idxs_req_if.sv -----
`timescale 1ns / 1ps

interface idxs_req_if;

    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [idxs_pkg::WORD_W-1:0]     rand_word;

    modport source (output valid, output cmd, output rand_word, input ready);
    modport sink (input valid, input cmd, input rand_word, output ready);

endinterface

// ----- design/idxs_res_if.sv -----
`timescale 1ns / 1ps

interface idxs_res_if;

    logic                            valid;
    logic                            ready;
    logic [idxs_pkg::PICK_W-1:0]     picked_index;
    idxs_pkg::t_status               status;
    logic                            last_draw;

    modport source (output valid, output picked_index, output status, output last_draw,
                    input ready);
    modport sink (input valid, input picked_index, input status, input last_draw,
                  output ready);

endinterface

// ----- design/idxs_ram.sv -----
`timescale 1ns / 1ps

module idxs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/idxs_mod_unit.sv -----
`timescale 1ns / 1ps

module idxs_mod_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [idxs_pkg::WORD_W-1:0]  i_dividend,
    input  logic [idxs_pkg::CNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [idxs_pkg::CNT_W-1:0]   o_rem
);

    localparam int STEP_W = $clog2(idxs_pkg::WORD_W);

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_cnt;
    logic [idxs_pkg::WORD_W-1:0]   r_quo;
    logic [idxs_pkg::CNT_W-1:0]    r_rem;
    logic [idxs_pkg::CNT_W-1:0]    r_div;
    logic [idxs_pkg::REM_W-1:0]    n_shift;
    logic [idxs_pkg::REM_W-1:0]    n_rem;

    always_comb begin
        n_shift = {r_rem, r_quo[idxs_pkg::WORD_W-1]};
        if (n_shift >= {1'b0, r_div}) begin
            n_rem = n_shift - {1'b0, r_div};
        end else begin
            n_rem = n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(idxs_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[idxs_pkg::WORD_W-2:0], 1'b0};
            r_rem <= n_rem[idxs_pkg::CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- design/index_sampler_without_replacement.sv -----
`timescale 1ns / 1ps

// A draw passes the bit-serial remainder unit, then the pool memory read (S_RDJ, S_RDT) and,
// without replacement only, the swap writes (S_WRJ, S_WRT) before its result is loaded in S_FIN.
// A start item, a limit or empty status goes straight to S_FIN; a new request is taken
// the cycle after a result is loaded, which waits while the result register is still full.
// A start item then rewrites the pool memory, one entry a cycle, before the next request.
// After reset the pool memory is loaded the same way, all MEM_DEPTH entries, taking no request.
module index_sampler_without_replacement #(
    parameter int POOL_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    idxs_req_if.sink                           i_req,
    idxs_res_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [idxs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [idxs_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int MEM_DEPTH = (POOL_DEPTH < 512) ? POOL_DEPTH : 512;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CAP       = (POOL_DEPTH < 511) ? POOL_DEPTH : 511;
    localparam int CW        = idxs_pkg::CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_RDJ   = 3'd2;
    localparam logic [2:0] S_RDT   = 3'd3;
    localparam logic [2:0] S_WRJ   = 3'd4;
    localparam logic [2:0] S_WRT   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_SWEEP = 3'd7;

    logic [2:0]                    r_state, n_state;
    logic [CW-1:0]                 r_remaining, n_remaining;
    logic [CW-1:0]                 r_draws, n_draws;
    logic [CW-1:0]                 r_cfg_count;
    logic                          r_cfg_repl;
    logic [CW-1:0]                 r_cfg_limit;
    logic [AW-1:0]                 r_sweep, n_sweep;
    logic                          r_ovalid, n_ovalid;

    logic [AW-1:0]                 r_j, n_j;
    logic [AW-1:0]                 r_t, n_t;
    logic [AW-1:0]                 r_val_j, n_val_j;
    idxs_pkg::t_status             r_status, n_status;
    logic                          r_last, n_last;
    logic [idxs_pkg::PICK_W-1:0]   r_opick, n_opick;
    idxs_pkg::t_status             r_ostatus, n_ostatus;
    logic                          r_olast, n_olast;

    logic                          req_fire;
    logic                          div_start;
    logic                          div_done;
    logic [CW-1:0]                 div_rem;
    logic [CW-1:0]                 eff_count;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [AW-1:0]                 mem_rdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && (r_state == S_IDLE);
    assign eff_count   = (r_cfg_count > CW'(CAP)) ? CW'(CAP) : r_cfg_count;

    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        n_draws     = r_draws;
        n_sweep     = r_sweep;
        n_ovalid    = r_ovalid;
        n_j         = r_j;
        n_t         = r_t;
        n_val_j     = r_val_j;
        n_status    = r_status;
        n_last      = r_last;
        n_opick     = r_opick;
        n_ostatus   = r_ostatus;
        n_olast     = r_olast;
        div_start   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_sweep;
        mem_wdata   = r_sweep;
        mem_raddr   = r_j;

        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_val_j = '0;
                    n_last  = 1'b0;
                    n_t     = AW'(r_remaining - 1'b1);
                    if (i_req.cmd == idxs_pkg::CMD_RESTART) begin
                        n_remaining = eff_count;
                        n_draws     = '0;
                        n_status    = idxs_pkg::ST_RESTART;
                        n_state     = S_FIN;
                    end else if (r_draws >= r_cfg_limit) begin
                        n_status = idxs_pkg::ST_LIMIT;
                        n_state  = S_FIN;
                    end else if (r_remaining == '0) begin
                        n_status = idxs_pkg::ST_EMPTY;
                        n_state  = S_FIN;
                    end else begin
                        n_status  = idxs_pkg::ST_DRAWN;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_j     = AW'(div_rem);
                    n_state = S_RDJ;
                end
            end
            S_RDJ: begin
                mem_raddr = r_j;
                n_state   = S_RDT;
            end
            S_RDT: begin
                mem_raddr = r_t;
                n_val_j   = mem_rdata;
                n_draws   = r_draws + 1'b1;
                n_last    = ((r_draws + 1'b1) == r_cfg_limit);
                n_state   = r_cfg_repl ? S_FIN : S_WRJ;
            end
            S_WRJ: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = mem_rdata;
                n_state   = S_WRT;
            end
            S_WRT: begin
                mem_we      = 1'b1;
                mem_waddr   = r_t;
                mem_wdata   = r_val_j;
                n_remaining = r_remaining - 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid  = 1'b1;
                    n_opick   = idxs_pkg::PICK_W'(r_val_j);
                    n_ostatus = r_status;
                    n_olast   = r_last;
                    n_sweep   = '0;
                    n_state   = (r_status == idxs_pkg::ST_RESTART) ? S_SWEEP : S_IDLE;
                end
            end
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = r_sweep;
                if (r_sweep == AW'(MEM_DEPTH - 1)) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_remaining <= CW'(CAP < 256 ? CAP : 256);
            r_draws     <= '0;
            r_sweep     <= '0;
            r_ovalid    <= 1'b0;
            r_cfg_count <= CW'(256);
            r_cfg_repl  <= 1'b0;
            r_cfg_limit <= CW'(256);
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_draws     <= n_draws;
            r_sweep     <= n_sweep;
            r_ovalid    <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    idxs_pkg::CFG_POOL_COUNT: r_cfg_count <= i_cfg_data;
                    idxs_pkg::CFG_WITH_REPL:  r_cfg_repl  <= i_cfg_data[0];
                    idxs_pkg::CFG_DRAW_LIMIT: r_cfg_limit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_t       <= n_t;
        r_val_j   <= n_val_j;
        r_status  <= n_status;
        r_last    <= n_last;
        r_opick   <= n_opick;
        r_ostatus <= n_ostatus;
        r_olast   <= n_olast;
    end

    idxs_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.rand_word),
        .i_divisor  (r_remaining),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    idxs_ram #(
        .WIDTH (AW),
        .DEPTH (MEM_DEPTH)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_res.valid        = r_ovalid;
    assign o_res.picked_index = r_opick;
    assign o_res.status       = r_ostatus;
    assign o_res.last_draw    = r_olast;

endmodule
